[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, sampled on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pmpr_pkg.sv]
// ---------------------------------------------------------------------------
// pmpr_pkg
// Shared types, constants and helper functions of the page replacement block.
// ---------------------------------------------------------------------------
package pmpr_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int PAGE_W     = 32;
	localparam int DRAW_W     = 31;
	localparam int SLOT_OUT_W = 8;

	// remainder unit: MOD_BITS dividend bits retired per cycle
	localparam int MOD_BITS   = 8;
	localparam int MOD_CYCLES = (DRAW_W + MOD_BITS - 1) / MOD_BITS;
	localparam int MOD_PAD_W  = MOD_CYCLES * MOD_BITS;
	localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

	typedef logic [SLOTS-1:0]  slot_vec_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              evict_hint;
		logic [DRAW_W-1:0] random_draw;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot_used;
		logic                  evicted;
		logic [PAGE_W-1:0]     evicted_page;
		logic                  phase_started;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MOD,
		ST_PICK,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic mod_step;
		logic pick;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic resolved;
		logic mod_last;
	} sts_t;

	function automatic cnt_t popcount(input slot_vec_t v);
		cnt_t n;
		n = '0;
		for (int i = 0; i < SLOTS; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	// lowest set bit, zero when none
	function automatic slot_idx_t first_set(input slot_vec_t v);
		slot_idx_t idx;
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[hdl/predicted_marking_page_replacement_top.sv]
// ---------------------------------------------------------------------------
// predicted_marking_page_replacement_top
// Fully associative page store with hint-steered randomized marking eviction.
// ---------------------------------------------------------------------------
//
//   channel   handshake            payload  direction
//   request   start && !busy       req      in
//   result    done (one cycle)     rsp      out
//
// Sequence: an item is taken in ST_IDLE; a hit or a miss into a free slot
// passes through ST_LOOKUP and ST_COMMIT before the next item can be taken.
// A miss on a full store adds the remainder unit's ST_MOD steps plus the
// ST_PICK victim-pick state between lookup and commit.
// The result strobe rises the cycle after commit, when busy is already low.
// Reset clears all slots to free, with their unmarked bits clear; page and hint entries are
// only read once their slot is valid. The receiver cannot stall results.
//
module predicted_marking_page_replacement_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pmpr_pkg::req_t req,
	output logic           done,
	output pmpr_pkg::rsp_t rsp
);
	import pmpr_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	// sequence each item: lookup, then remainder and pick only on a full-store miss
	pmpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// hold the slot store, drive the registered result and its strobe
	pmpr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

[hdl/pmpr_mod.sv]
// ---------------------------------------------------------------------------
// pmpr_mod
// Iterative remainder unit: draw mod count, MOD_BITS bits per cycle.
// ---------------------------------------------------------------------------
module pmpr_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         init,
	input  logic                         step,
	input  logic [pmpr_pkg::DRAW_W-1:0]  draw,
	input  pmpr_pkg::cnt_t               divisor,
	output pmpr_pkg::cnt_t               rem,
	output logic                         last
);
	import pmpr_pkg::*;

	logic [MOD_PAD_W-1:0] dividend_q;
	cnt_t                 divisor_q;
	cnt_t                 rem_q;
	logic [MOD_CNT_W-1:0] step_q;
	logic [CNT_W:0]       rem_next;

	// shift in one dividend bit, subtract once: partial remainder stays below divisor
	always_comb begin
		rem_next = {1'b0, rem_q};
		for (int j = 0; j < MOD_BITS; j++) begin
			rem_next = {rem_next[CNT_W-1:0], dividend_q[MOD_PAD_W-1-j]};
			if (rem_next >= {1'b0, divisor_q}) begin
				rem_next = rem_next - {1'b0, divisor_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (init) begin
			step_q <= '0;
		end else if (step) begin
			step_q <= step_q + MOD_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			dividend_q <= MOD_PAD_W'(draw);
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (step) begin
			dividend_q <= dividend_q << MOD_BITS;
			rem_q      <= rem_next[CNT_W-1:0];
		end
	end

	assign rem  = rem_q;
	assign last = (step_q == MOD_CNT_W'(MOD_CYCLES - 1));

endmodule

[hdl/pmpr_dp.sv]
// ---------------------------------------------------------------------------
// pmpr_dp
// Datapath: slot store, tag match, candidate set, victim rank select, result.
// ---------------------------------------------------------------------------
module pmpr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  pmpr_pkg::cmd_t cmd,
	input  pmpr_pkg::req_t req,
	output pmpr_pkg::sts_t sts,
	output logic           done,
	output pmpr_pkg::rsp_t rsp
);
	import pmpr_pkg::*;

	// slot store
	slot_vec_t         valid_q;
	slot_vec_t         unmarked_q;
	slot_vec_t         hint_q;
	logic [PAGE_W-1:0] page_q [SLOTS];

	// request and lookup outcome
	req_t      req_q;
	logic      hit_q;
	logic      evict_q;
	logic      phase_q;
	slot_idx_t target_q;
	slot_vec_t cand_q;
	rsp_t      rsp_q;
	logic      done_q;

	slot_vec_t match;
	slot_vec_t um;
	slot_vec_t cand1;
	slot_vec_t cand0;
	slot_vec_t cand;
	slot_vec_t unmarked_next;
	logic      hit;
	logic      have_free;
	logic      need_phase;
	cnt_t      cand_cnt;
	cnt_t      rank;
	slot_idx_t pick_idx;
	logic      mod_last;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (page_q[i] == req_q.page_number);
		end
		hit        = |match;
		have_free  = ~&valid_q;
		need_phase = ~|(valid_q & unmarked_q);
		um         = need_phase ? valid_q : (valid_q & unmarked_q);
		cand1      = um & hint_q;
		cand0      = um & ~hint_q;
		cand       = (|cand1) ? cand1 : cand0;
		cand_cnt   = popcount(cand);
	end

	pmpr_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.init    (cmd.lookup),
		.step    (cmd.mod_step),
		.draw    (req_q.random_draw),
		.divisor (cand_cnt),
		.rem     (rank),
		.last    (mod_last)
	);

	// candidate whose count of lower candidates equals the rank
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (cand_q[i] && (popcount(cand_q & ((slot_vec_t'(1) << i) - slot_vec_t'(1)))
					== rank)) begin
				pick_idx = pick_idx | SLOT_W'(i);
			end
		end
	end

	always_comb begin
		unmarked_next           = phase_q ? valid_q : unmarked_q;
		unmarked_next[target_q] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			unmarked_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				valid_q[target_q] <= 1'b1;
				unmarked_q        <= unmarked_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.lookup) begin
			hit_q    <= hit;
			evict_q  <= !hit && !have_free;
			phase_q  <= !hit && !have_free && need_phase;
			target_q <= hit ? first_set(match) : first_set(~valid_q);
			cand_q   <= cand;
		end else if (cmd.pick) begin
			target_q <= pick_idx;
		end
		if (cmd.commit) begin
			if (!hit_q) begin
				page_q[target_q] <= req_q.page_number;
			end
			hint_q[target_q]    <= req_q.evict_hint;
			rsp_q.hit           <= hit_q;
			rsp_q.slot_used     <= SLOT_OUT_W'(target_q);
			rsp_q.evicted       <= evict_q;
			rsp_q.evicted_page  <= evict_q ? page_q[target_q] : '0;
			rsp_q.phase_started <= phase_q;
		end
	end

	assign sts.resolved = hit || have_free;
	assign sts.mod_last = mod_last;
	assign done         = done_q;
	assign rsp          = rsp_q;

endmodule

[hdl/pmpr_ctrl.sv]
// ---------------------------------------------------------------------------
// pmpr_ctrl
// Controller: sequences lookup, remainder, victim pick and commit per item.
// ---------------------------------------------------------------------------
module pmpr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pmpr_pkg::sts_t sts,
	output logic           busy,
	output pmpr_pkg::cmd_t cmd
);
	import pmpr_pkg::*;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_next = sts.resolved ? ST_COMMIT : ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_last) begin
					state_next = ST_PICK;
				end
			end
			ST_PICK:   state_next = ST_COMMIT;
			ST_COMMIT: state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_LOOKUP: cmd.lookup   = 1'b1;
			ST_MOD:    cmd.mod_step = 1'b1;
			ST_PICK:   cmd.pick     = 1'b1;
			ST_COMMIT: cmd.commit   = 1'b1;
			default:   busy         = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

[hdl/pmpr_checker.sv]
// ---------------------------------------------------------------------------
// pmpr_checker
// Port-level checks of the page replacement block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmpr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input pmpr_pkg::rsp_t rsp
);
	import pmpr_pkg::*;

	`ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	`ASSERT_NEXT(a_take_busy, start && !busy, busy, "item taken but not busy")
	`ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`ASSERT_NOW(a_hit_clean, done && rsp.hit, !rsp.evicted && !rsp.phase_started, "hit evicted")
	`ASSERT_NOW(a_no_evict_zero, done && !rsp.evicted, rsp.evicted_page == '0 && !rsp.phase_started, "stray eviction data")

endmodule

bind predicted_marking_page_replacement_top pmpr_checker u_pmpr_checker (.*);

[test/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the hint-steered marking page store. A driver
// feeds request items from a queue, a monitor checks every result strobe
// against an in-bench replica of the slot store, in order, field by field.
// ---------------------------------------------------------------------------
module testbench;

	import pmpr_pkg::*;

	// keep the tail of the run free of sender gaps
	localparam int TAIL_ITEMS   = 150;
	localparam int RANDOM_ITEMS = 1330;
	localparam int POOL_MAX     = 40;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};
	localparam logic [DRAW_W-1:0] DRAW_MAX = {DRAW_W{1'b1}};

	typedef struct {
		req_t req;
		bit   drain;	// hold this item until every outstanding result is back
	} request_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	request_item_t request_q[$];
	rsp_t          outcome_q[$];
	int            errors = 0;

	// replica of the slot store
	bit                slot_valid    [SLOTS];
	logic [PAGE_W-1:0] slot_page     [SLOTS];
	bit                slot_hint     [SLOTS];
	bit                slot_unmarked [SLOTS];

	// driver bookkeeping
	bit took;
	int gap_left = 0;

	predicted_marking_page_replacement_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count resident unmarked pages that carry the given hint.
	function automatic int unsigned count_unmarked(input bit want_hint);
		int unsigned n;
		n = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_valid[s] && slot_unmarked[s] && slot_hint[s] == want_hint) begin
				n++;
			end
		end
		return n;
	endfunction

	// Apply one request to the replica and return the outcome it must produce.
	function automatic rsp_t access_outcome(input req_t r);
		rsp_t        o;
		int          tgt;
		bit          found;
		bit          have_free;
		bit          picked;
		bit          grp;
		int unsigned n1;
		int unsigned n0;
		int unsigned n;
		int unsigned rank;
		o     = '0;
		tgt   = 0;
		found = 1'b0;
		// tag match: first valid slot holding the page
		for (int s = 0; s < SLOTS; s++) begin
			if (!found && slot_valid[s] && slot_page[s] == r.page_number) begin
				tgt   = s;
				found = 1'b1;
			end
		end
		if (found) begin
			o.hit = 1'b1;
		end else begin
			have_free = 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				if (!have_free && !slot_valid[s]) begin
					tgt       = s;
					have_free = 1'b1;
				end
			end
			if (!have_free) begin
				n1 = count_unmarked(1'b1);
				n0 = count_unmarked(1'b0);
				// nothing unmarked: open a new phase, unmark every resident page
				if (n1 == 0 && n0 == 0) begin
					for (int s = 0; s < SLOTS; s++) begin
						slot_unmarked[s] = slot_valid[s];
					end
					o.phase_started = 1'b1;
					n1 = count_unmarked(1'b1);
					n0 = count_unmarked(1'b0);
				end
				// prefer pages predicted for eviction
				grp  = (n1 > 0);
				n    = grp ? n1 : n0;
				if (n == 0) begin
					n = 1;
				end
				rank   = r.random_draw % n;
				picked = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!picked && slot_valid[s] && slot_unmarked[s] && slot_hint[s] == grp) begin
						if (rank == 0) begin
							tgt    = s;
							picked = 1'b1;
						end else begin
							rank--;
						end
					end
				end
				o.evicted      = 1'b1;
				o.evicted_page = slot_page[tgt];
			end
			slot_valid[tgt] = 1'b1;
			slot_page[tgt]  = r.page_number;
		end
		// every request records its hint and leaves its page marked
		slot_hint[tgt]     = r.evict_hint;
		slot_unmarked[tgt] = 1'b0;
		o.slot_used        = SLOT_OUT_W'(tgt);
		return o;
	endfunction

	task automatic add_request(input logic [PAGE_W-1:0] page, input bit hint,
	                           input logic [DRAW_W-1:0] draw, input bit drain);
		request_item_t it;
		it.req.page_number = page;
		it.req.evict_hint  = hint;
		it.req.random_draw = draw;
		it.drain           = drain;
		request_q.insert(request_q.size(), it);
	endtask

	task automatic check_field(input string name, input logic [PAGE_W-1:0] want,
	                           input logic [PAGE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: present the head of the request queue, predict on acceptance,
	// and insert random idle bursts between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				outcome_q.insert(outcome_q.size(), access_outcome(req));
				void'(request_q.pop_front());
				// idle now and then, but never in the tail of the run
				if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
					gap_left = $urandom_range(1, 7);
				end
			end
			// hold start high until the presented item is taken
			if (!start || took) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (request_q.size() == 0) begin
					start <= 1'b0;
				end else if (request_q[0].drain && outcome_q.size() != 0) begin
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					req   <= request_q[0].req;
				end
			end
		end
	end

	// Monitor: every strobe must match the oldest outstanding outcome.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, rsp);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				check_field("hit", PAGE_W'(want.hit), PAGE_W'(rsp.hit));
				check_field("slot_used", PAGE_W'(want.slot_used), PAGE_W'(rsp.slot_used));
				check_field("evicted", PAGE_W'(want.evicted), PAGE_W'(rsp.evicted));
				check_field("evicted_page", want.evicted_page, rsp.evicted_page);
				check_field("phase_started", PAGE_W'(want.phase_started),
				            PAGE_W'(rsp.phase_started));
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [PAGE_W-1:0] pool [POOL_MAX];
		logic [PAGE_W-1:0] page;
		logic [DRAW_W-1:0] draw;
		int                pool_size;
		int                hint_bias;
		int                pick;
		for (int k = 0; k < POOL_MAX; k++) begin
			pool[k] = $urandom;
		end
		pool_size = 20;
		hint_bias = 2;

		// extremes of page and draw, a hit that flips the stored hint
		add_request('0, 1'b1, '0, 1'b0);
		add_request(PAGE_MAX, 1'b0, DRAW_MAX, 1'b0);
		add_request('0, 1'b0, DRAW_MAX, 1'b0);
		// fill the store through the lowest free slot
		for (int k = 0; k < SLOTS - 2; k++) begin
			add_request(PAGE_W'(32'h100 + k), k[0], DRAW_W'(k), 1'b0);
		end
		// full store with everything marked: a new phase opens
		add_request(32'hA5A5_A5A5, 1'b1, DRAW_MAX, 1'b0);
		// unmarked candidates remain: evict without a phase change
		add_request(32'h5A5A_5A5A, 1'b0, DRAW_W'(3), 1'b0);
		// hits on pages that may have become unmarked, then a new page held until all results are back
		add_request(32'h0000_0100, 1'b1, '0, 1'b0);
		add_request(PAGE_MAX, 1'b1, '0, 1'b0);
		add_request(32'h1234_5678, 1'b0, '0, 1'b1);

		// random part: mostly accesses drawn from a working set that shifts
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0) begin
				pool_size = $urandom_range(SLOTS + 1, POOL_MAX);
				hint_bias = $urandom_range(0, 4);
				for (int k = 0; k < POOL_MAX; k++) begin
					if ($urandom_range(0, 2) == 0) begin
						pool[k] = $urandom;
					end
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				page = pool[$urandom_range(0, pool_size - 1)];
			end else if (pick < 95) begin
				page = $urandom;
			end else begin
				page = pick[0] ? PAGE_MAX : '0;
			end
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				draw = '0;
			end else if (pick == 1) begin
				draw = DRAW_MAX;
			end else begin
				draw = DRAW_W'($urandom);
			end
			add_request(page, $urandom_range(0, 3) < hint_bias, draw, i == RANDOM_ITEMS / 2);
		end

		// release reset away from the active clock edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last item and its result, then let the block settle
		while (request_q.size() != 0 || outcome_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/pmpr_pkg.sv
hdl/pmpr_mod.sv
hdl/pmpr_dp.sv
hdl/pmpr_ctrl.sv
hdl/predicted_marking_page_replacement_top.sv
hdl/pmpr_checker.sv
test/testbench.sv
